@@ src/hgse_pkg.sv @@
// Package for the hex grid successor expander: types, codes, constants, offset tables.
`default_nettype none
package hgse_pkg;

   // default sizes
   localparam int GRID_DIM_DEF  = 64;
   localparam int MAX_GOALS_DEF = 8;

   // action codes
   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_GOAL   = 2'd1;
   localparam logic [1:0] ACT_EXPAND = 2'd2;

   // register indexes
   localparam logic [1:0] REG_COL_MIN = 2'd0;
   localparam logic [1:0] REG_COL_MAX = 2'd1;
   localparam logic [1:0] REG_ROW_MIN = 2'd2;
   localparam logic [1:0] REG_ROW_MAX = 2'd3;

   // distance arithmetic: row pitch 0.866025 in Q0.16 and its square
   localparam longint unsigned Y_STEP_Q16 = 56756;
   localparam logic [31:0] Y_STEP_SQ = 32'(Y_STEP_Q16 * Y_STEP_Q16);
   localparam int HALF_SQ_SHIFT = 30;   // (2^15)^2
   localparam int RAD_W  = 46;          // squared distance, Q32
   localparam int ROOT_W = 23;          // distance, Q16

   typedef struct packed {
      logic [1:0]  action;
      logic [5:0]  cell_col;
      logic [5:0]  cell_row;
      logic        blocked;
      logic [5:0]  parent_col;
      logic [5:0]  parent_row;
      logic [15:0] path_cost;
   } req_type;

   typedef struct packed {
      logic [5:0]  succ_col;
      logic [5:0]  succ_row;
      logic [15:0] succ_cost;
      logic [15:0] heuristic;
      logic        last;
   } rsp_type;

   // column offset of direction dir
   function automatic logic signed [1:0] nb_dc(input logic odd, input logic [2:0] dir);
      logic signed [1:0] v;
      case (dir)
         3'd0:    v = -2'sd1;
         3'd1:    v = odd ? -2'sd1 : 2'sd0;
         3'd2:    v = odd ? 2'sd0 : 2'sd1;
         3'd3:    v = 2'sd1;
         3'd4:    v = odd ? 2'sd0 : 2'sd1;
         3'd5:    v = odd ? -2'sd1 : 2'sd0;
         default: v = 2'sd0;
      endcase
      return v;
   endfunction

   // row offset of direction dir (same for both parities)
   function automatic logic signed [1:0] nb_dr(input logic [2:0] dir);
      logic signed [1:0] v;
      case (dir)
         3'd0:    v = 2'sd0;
         3'd1:    v = -2'sd1;
         3'd2:    v = -2'sd1;
         3'd3:    v = 2'sd0;
         3'd4:    v = 2'sd1;
         3'd5:    v = 2'sd1;
         default: v = 2'sd0;
      endcase
      return v;
   endfunction

   // direction of slot j: root takes all six, otherwise the three facing away
   function automatic logic [2:0] nb_dir(input logic root, input logic [2:0] kpar,
                                         input logic [2:0] j);
      logic [3:0] s;
      s = 4'(kpar) + 4'd2 + 4'(j);
      if (s >= 4'd6) s = s - 4'd6;
      return root ? j : s[2:0];
   endfunction

endpackage
`default_nettype wire

@@ src/hex_grid_successor_expander.sv @@
// Top level of the hex grid successor expander.
//
// Input channel req_*: one word per item (obstacle load, goal append or node
// expansion), accepted when req_valid is high and req_stall low. Result
// channel rsp_*: one word per successor, taken when rsp_valid is high and
// rsp_stall low; last marks the final successor of an expansion.
// Configuration port csr_*: bound registers, always ready, to be written when idle;
// the block itself does not enforce that. Loads and goal appends are done at
// accept and leave the engine idle. An expansion first scans its neighbor slots
// against the obstacle RAM, then for every surviving successor walks the goal
// RAM one goal at a time, each distance taken by the bit-serial square root.
// With no goals loaded, each successor is emitted without a goal walk.
// One item is worked at a time; a finished word waits in the output register
// while the next item is accepted. A stalled receiver holds the word and the
// engine waits only when its next word has nowhere to go.
// After reset the obstacle RAM is cleared one cell per cycle,
// all GRID_DIM*GRID_DIM cells, while req_stall stays high.
`default_nettype none
module hex_grid_successor_expander
   import hgse_pkg::*;
#(
   parameter int GRID_DIM  = GRID_DIM_DEF,
   parameter int MAX_GOALS = MAX_GOALS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [5:0] csr_data
);
   localparam int ODEPTH = GRID_DIM * GRID_DIM;
   localparam int OAW    = $clog2(ODEPTH);
   localparam int GAW    = (MAX_GOALS > 1) ? $clog2(MAX_GOALS) : 1;
   localparam int GCW    = $clog2(MAX_GOALS + 1);

   localparam logic [3:0] S_CLEAR = 4'd0,  S_IDLE  = 4'd1,  S_SCAN  = 4'd2,
                          S_DRAIN = 4'd3,  S_PICK  = 4'd4,  S_GREAD = 4'd5,
                          S_GDIFF = 4'd6,  S_GSQ   = 4'd7,  S_GMUL  = 4'd8,
                          S_GSTRT = 4'd9,  S_ROOT  = 4'd10, S_EMIT  = 4'd11;

   logic [3:0]  state_ff, state_in;
   logic [5:0]  col_min_ff, col_max_ff, row_min_ff, row_max_ff;
   logic [OAW-1:0] clr_ff;
   logic [5:0]  ncol_ff, nrow_ff;
   logic        root_ff;
   logic [2:0]  kpar_ff, nsel_ff, j_ff, jd_ff;
   logic        chk_ff, inb_ff;
   logic [5:0]  mask_ff;
   logic [15:0] scost_ff, best_ff;
   logic [5:0]  sc_ff, sr_ff;
   logic [GCW-1:0] g_ff, gcnt_ff;
   logic [6:0]  adx_ff;
   logic [5:0]  ady_ff;
   logic [13:0] sqx_ff;
   logic [11:0] sqy_ff;
   logic [RAD_W-1:0] ax2_ff, ay2_ff;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff;

   logic        accept, out_free, out_load, last_bit;
   logic        ob_we, ob_rdata, ob_wdata, gl_we;
   logic [OAW-1:0] ob_waddr, ob_raddr;
   logic [11:0] gl_rdata;
   logic        is_root, is_adj;
   logic [2:0]  adj_k;
   logic [2:0]  dir;
   logic signed [9:0] nc, nr;
   logic        inb;
   logic        sq_start, sq_done;
   logic [ROOT_W-1:0] sq_root;
   logic [15:0] cand;
   logic signed [8:0] dxh;
   logic signed [6:0] dry;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         col_min_ff <= '0;
         col_max_ff <= 6'd63;
         row_min_ff <= '0;
         row_max_ff <= 6'd63;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_COL_MIN: col_min_ff <= csr_data;
            REG_COL_MAX: col_max_ff <= csr_data;
            REG_ROW_MIN: row_min_ff <= csr_data;
            REG_ROW_MAX: row_max_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // parent classification at accept
   always_comb begin
      logic signed [9:0] pc, pr;
      is_root = (req_data.parent_col == req_data.cell_col) &&
                (req_data.parent_row == req_data.cell_row);
      is_adj = 1'b0;
      adj_k  = '0;
      for (int k = 0; k < 6; k++) begin
         pc = $signed({4'b0, req_data.cell_col}) + 10'(nb_dc(req_data.cell_row[0], 3'(k)));
         pr = $signed({4'b0, req_data.cell_row}) + 10'(nb_dr(3'(k)));
         if (!is_adj && (pc == $signed({4'b0, req_data.parent_col})) &&
             (pr == $signed({4'b0, req_data.parent_row}))) begin
            is_adj = 1'b1;
            adj_k  = 3'(k);
         end
      end
   end

   // neighbor of the current slot and its bounds check
   assign dir = nb_dir(root_ff, kpar_ff, j_ff);
   assign nc  = $signed({4'b0, ncol_ff}) + 10'(nb_dc(nrow_ff[0], dir));
   assign nr  = $signed({4'b0, nrow_ff}) + 10'(nb_dr(dir));
   assign inb = (nc >= $signed({4'b0, col_min_ff})) && (nc <= $signed({4'b0, col_max_ff})) &&
                (nc < $signed(10'(GRID_DIM))) &&
                (nr >= $signed({4'b0, row_min_ff})) && (nr <= $signed({4'b0, row_max_ff})) &&
                (nr < $signed(10'(GRID_DIM)));

   // obstacle RAM: clear sweep and loads write, the scan reads; never at once
   always_comb begin
      ob_we    = 1'b0;
      ob_waddr = clr_ff;
      ob_wdata = 1'b0;
      if (state_ff == S_CLEAR) begin
         ob_we = 1'b1;
      end else if (accept && (req_data.action == ACT_LOAD) &&
                   (32'(req_data.cell_col) < 32'(GRID_DIM)) &&
                   (32'(req_data.cell_row) < 32'(GRID_DIM))) begin
         ob_we    = 1'b1;
         ob_waddr = OAW'(32'(req_data.cell_row) * 32'(GRID_DIM) + 32'(req_data.cell_col));
         ob_wdata = req_data.blocked;
      end
   end
   assign ob_raddr = OAW'(32'(nr[5:0]) * 32'(GRID_DIM) + 32'(nc[5:0]));

   hgse_ram #(.WIDTH(1), .DEPTH(ODEPTH)) u_obst (
      .clock (clock),
      .we    (ob_we),
      .waddr (ob_waddr),
      .wdata (ob_wdata),
      .raddr (ob_raddr),
      .rdata (ob_rdata)
   );

   // goal RAM: appended at accept, read one goal per pass
   assign gl_we = accept && (req_data.action == ACT_GOAL) && (gcnt_ff < GCW'(MAX_GOALS));

   hgse_ram #(.WIDTH(12), .DEPTH(MAX_GOALS)) u_goal (
      .clock (clock),
      .we    (gl_we),
      .waddr (gcnt_ff[GAW-1:0]),
      .wdata ({req_data.cell_row, req_data.cell_col}),
      .raddr (g_ff[GAW-1:0]),
      .rdata (gl_rdata)
   );

   // distance components against the goal just read
   assign dxh = $signed({2'b0, sc_ff, 1'b0}) - $signed({8'b0, sr_ff[0]}) -
                ($signed({2'b0, gl_rdata[5:0], 1'b0}) - $signed({8'b0, gl_rdata[6]}));
   assign dry = $signed({1'b0, sr_ff}) - $signed({1'b0, gl_rdata[11:6]});

   assign sq_start = (state_ff == S_GSTRT);

   hgse_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (ax2_ff + ay2_ff),
      .done    (sq_done),
      .root    (sq_root)
   );

   assign cand = {1'b0, sq_root[ROOT_W-1:8]};

   // output register
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = (state_ff == S_EMIT) && out_free;
   always_comb begin
      last_bit = 1'b1;
      for (int i = 0; i < 6; i++)
         if ((3'(i) > j_ff) && mask_ff[i]) last_bit = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (out_load) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      if (out_load) rsp_ff <= '{succ_col: sc_ff, succ_row: sr_ff, succ_cost: scost_ff,
                                 heuristic: best_ff, last: last_bit};
   end
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_ff == OAW'(ODEPTH - 1)) state_in = S_IDLE;
         S_IDLE:  if (accept && (req_data.action == ACT_EXPAND) && (is_root || is_adj))
                     state_in = S_SCAN;
         S_SCAN:  if (j_ff == nsel_ff - 3'd1) state_in = S_DRAIN;
         S_DRAIN: state_in = S_PICK;
         S_PICK:  begin
            if (j_ff == nsel_ff) state_in = S_IDLE;
            else if (mask_ff[j_ff]) state_in = (gcnt_ff == '0) ? S_EMIT : S_GREAD;
         end
         S_GREAD: state_in = S_GDIFF;
         S_GDIFF: state_in = S_GSQ;
         S_GSQ:   state_in = S_GMUL;
         S_GMUL:  state_in = S_GSTRT;
         S_GSTRT: state_in = S_ROOT;
         S_ROOT:  if (sq_done) state_in = (GCW'(g_ff + 1'b1) == gcnt_ff) ? S_EMIT : S_GREAD;
         S_EMIT:  if (out_free) state_in = S_PICK;
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         gcnt_ff  <= '0;
         chk_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (gl_we) gcnt_ff <= gcnt_ff + 1'b1;
         chk_ff <= (state_ff == S_SCAN);
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         ncol_ff  <= req_data.cell_col;
         nrow_ff  <= req_data.cell_row;
         root_ff  <= is_root;
         kpar_ff  <= adj_k;
         nsel_ff  <= is_root ? 3'd6 : 3'd3;
         scost_ff <= (req_data.path_cost == 16'hFFFF) ? 16'hFFFF : req_data.path_cost + 1'b1;
         j_ff     <= '0;
         mask_ff  <= '0;
      end
      // scan: read cell of slot j, record it in the next cycle
      if (state_ff == S_SCAN) begin
         jd_ff  <= j_ff;
         inb_ff <= inb;
         j_ff   <= (j_ff == nsel_ff - 3'd1) ? 3'd0 : j_ff + 3'd1;
      end
      if (chk_ff) mask_ff[jd_ff] <= inb_ff && !ob_rdata;
      if (state_ff == S_PICK && j_ff != nsel_ff) begin
         if (!mask_ff[j_ff]) j_ff <= j_ff + 3'd1;
         sc_ff   <= nc[5:0];
         sr_ff   <= nr[5:0];
         best_ff <= 16'hFFFF;
         g_ff    <= '0;
      end
      if (state_ff == S_GDIFF) begin
         adx_ff <= (dxh < 0) ? 7'(-dxh) : 7'(dxh);
         ady_ff <= (dry < 0) ? 6'(-dry) : 6'(dry);
      end
      if (state_ff == S_GSQ) begin
         sqx_ff <= 14'(adx_ff * adx_ff);
         sqy_ff <= 12'(ady_ff * ady_ff);
      end
      if (state_ff == S_GMUL) begin
         ax2_ff <= RAD_W'(sqx_ff) << HALF_SQ_SHIFT;
         ay2_ff <= RAD_W'(sqy_ff * Y_STEP_SQ);
      end
      if (state_ff == S_ROOT && sq_done) begin
         if (cand < best_ff) best_ff <= cand;
         g_ff <= g_ff + 1'b1;
      end
      if (out_load) j_ff <= j_ff + 3'd1;
   end
endmodule
`default_nettype wire

@@ src/hgse_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module hgse_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

@@ src/hgse_isqrt.sv @@
// Bit-serial truncating integer square root, one result bit per cycle.
`default_nettype none
module hgse_isqrt
   import hgse_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [RAD_W-1:0]  operand,
   output logic                   done,
   output logic      [ROOT_W-1:0] root
);
   localparam int CW = $clog2(ROOT_W);

   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W+1:0] rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CW-1:0]     cnt_ff;
   logic              busy_ff, done_ff;
   logic [ROOT_W+2:0] rem_sh, trial;
   logic              take;

   // shift in two radicand bits, try subtracting 4*root+1
   assign rem_sh = {rem_ff[ROOT_W:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign take   = (rem_sh >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start) busy_ff <= 1'b1;
         else if (busy_ff && (cnt_ff == '0)) busy_ff <= 1'b0;
      end
      if (start) begin
         rad_ff  <= operand;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= CW'(ROOT_W - 1);
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= take ? (ROOT_W+2)'(rem_sh - trial) : rem_sh[ROOT_W+1:0];
         root_ff <= {root_ff[ROOT_W-2:0], take};
         cnt_ff  <= cnt_ff - 1'b1;
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

@@ src/hgse_checker.sv @@
// Port-level checker for the hex grid successor expander, bound to the top level.
`default_nettype none
module hgse_checker
   import hgse_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);
   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed under stall");

   // clear pass keeps the input closed right after reset
   a_clear: assert property (@(posedge clock) reset |=> req_stall)
      else $error("input open during clear pass");

   // incremented cost never wraps to zero
   a_cost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.succ_cost != 16'd0)
      else $error("successor cost zero");

   // distance fits in 15 bits unless no goal is loaded
   a_heur: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.heuristic[15] == 1'b0 || rsp_data.heuristic == 16'hFFFF))
      else $error("heuristic out of range");
endmodule

bind hex_grid_successor_expander hgse_checker u_hgse_checker (.*);
`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for the hex grid successor expander: predicts successors and checks each result word.
module tb_top
   import hgse_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GDIM = 64;
   localparam int NGOAL = 8;
   localparam int ROW_STEP = 56756;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [5:0] csr_data = '0;

   hex_grid_successor_expander dut (.*);

   always #5 clock = ~clock;

   // shadow state of the block
   bit         blk_map [GDIM*GDIM];
   logic [5:0] goal_c [NGOAL];
   logic [5:0] goal_r [NGOAL];
   int         n_goals;
   int         lim_cmin, lim_cmax, lim_rmin, lim_rmax;
   rsp_type    succ_q[$];
   int         n_errs;
   bit         sink_idle_on = 1'b1;
   bit         src_idle_on = 1'b1;
   int         hold_cycles = 0;

   // neighbor offsets, odd and even rows
   int odd_dc[6]  = '{-1, -1, 0, 1, 0, -1};
   int even_dc[6] = '{-1, 0, 1, 1, 1, 0};
   int all_dr[6]  = '{0, -1, -1, 0, 1, 1};

   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // shortest goal distance in Q8.8
   function automatic logic [15:0] goal_dist(int c, int r);
      longint unsigned best, ax, ay, d;
      int xh, dxh, dr;
      best = 65535;
      xh = 2*c - (r & 1);
      for (int g = 0; g < n_goals; g++) begin
         dxh = xh - (2*int'(goal_c[g]) - int'(goal_r[g][0]));
         dr = r - int'(goal_r[g]);
         ax = longint'(dxh < 0 ? -dxh : dxh) * 32768;
         ay = longint'(dr < 0 ? -dr : dr) * ROW_STEP;
         d = int_root(ax*ax + ay*ay) >> 8;
         if (d < best) best = d;
      end
      return best[15:0];
   endfunction

   // apply one item to the shadow state and queue its successors
   task automatic predict_item(req_type it);
      int dirs[6];
      int nd, c, r, cnt;
      int col, row;
      rsp_type w;
      nd = 0;
      col = it.cell_col;
      row = it.cell_row;
      if (it.action == ACT_LOAD) begin
         blk_map[row*GDIM + col] = it.blocked;
         return;
      end
      if (it.action == ACT_GOAL) begin
         if (n_goals < NGOAL) begin
            goal_c[n_goals] = it.cell_col;
            goal_r[n_goals] = it.cell_row;
            n_goals++;
         end
         return;
      end
      if (it.action != ACT_EXPAND) return;
      if (it.parent_col == it.cell_col && it.parent_row == it.cell_row) begin
         for (int k = 0; k < 6; k++) dirs[nd++] = k;
      end else begin
         for (int k = 0; k < 6; k++) begin
            c = col + (row[0] ? odd_dc[k] : even_dc[k]);
            r = row + all_dr[k];
            if (nd == 0 && int'(it.parent_col) == c && int'(it.parent_row) == r) begin
               for (int j = 0; j < 3; j++) dirs[nd++] = (k + 2 + j) % 6;
            end
         end
      end
      cnt = 0;
      for (int j = 0; j < nd; j++) begin
         c = col + (row[0] ? odd_dc[dirs[j]] : even_dc[dirs[j]]);
         r = row + all_dr[dirs[j]];
         if (c < lim_cmin || c > lim_cmax || r < lim_rmin || r > lim_rmax) continue;
         if (blk_map[r*GDIM + c]) continue;
         w.succ_col = c[5:0];
         w.succ_row = r[5:0];
         w.succ_cost = (it.path_cost == 16'hFFFF) ? 16'hFFFF : it.path_cost + 16'd1;
         w.heuristic = goal_dist(c, r);
         w.last = 1'b0;
         succ_q = {succ_q, w};
         cnt++;
      end
      if (cnt > 0) succ_q[succ_q.size()-1].last = 1'b1;
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
      n_errs++;
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (succ_q.size() == 0) begin
            report_mismatch("unexpected word, col", rsp_data.succ_col, -1);
         end else begin
            want = succ_q.pop_front();
            if (rsp_data.succ_col != want.succ_col)
               report_mismatch("succ_col", rsp_data.succ_col, want.succ_col);
            if (rsp_data.succ_row != want.succ_row)
               report_mismatch("succ_row", rsp_data.succ_row, want.succ_row);
            if (rsp_data.succ_cost != want.succ_cost)
               report_mismatch("succ_cost", rsp_data.succ_cost, want.succ_cost);
            if (rsp_data.heuristic != want.heuristic)
               report_mismatch("heuristic", rsp_data.heuristic, want.heuristic);
            if (rsp_data.last != want.last)
               report_mismatch("last", rsp_data.last, want.last);
         end
      end
   end

   // receiver stall: random bursts, or a long counted hold-off
   int sink_burst = 0;
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (sink_burst > 0) begin
         sink_burst <= sink_burst - 1;
         rsp_stall <= 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
         sink_burst <= $urandom_range(0, 17);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // send one word, with an optional idle burst before it; valid stays up
   // after acceptance so that words can follow back to back
   task automatic send_item(req_type it);
      int gap;
      if (src_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_item(it);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (succ_q.size() != 0) @(posedge clock);
      // goal distance for six successors and all goals
      repeat (2000) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [5:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_COL_MIN: lim_cmin = v;
         REG_COL_MAX: lim_cmax = v;
         REG_ROW_MIN: lim_rmin = v;
         default:     lim_rmax = v;
      endcase
   endtask

   function automatic req_type make_item(logic [1:0] act, int c, int r, int pc, int pr,
                                         int cost, bit b);
      req_type it;
      it.action = act;
      it.cell_col = c[5:0];
      it.cell_row = r[5:0];
      it.blocked = b;
      it.parent_col = pc[5:0];
      it.parent_row = pr[5:0];
      it.path_cost = cost[15:0];
      return it;
   endfunction

   // expansion of a cell whose parent is its neighbor in direction k, wrapped to 6 bits
   function automatic req_type expand_from(int c, int r, int k, int cost);
      int pc, pr;
      pc = c + (r[0] ? odd_dc[k] : even_dc[k]);
      pr = r + all_dr[k];
      return make_item(ACT_EXPAND, c, r, pc, pr, cost, 1'b0);
   endfunction

   // roots and parents before any goal, extreme corners and costs
   task automatic test_no_goals;
      send_item(make_item(ACT_EXPAND, 0, 0, 0, 0, 0, 0));
      send_item(make_item(ACT_EXPAND, 63, 63, 63, 63, 65535, 0));
      send_item(make_item(ACT_EXPAND, 10, 11, 10, 11, 65534, 0));
      for (int k = 0; k < 6; k++) begin
         send_item(expand_from(20, 21, k, k));
         send_item(expand_from(20, 22, k, 100));
      end
      send_item(make_item(ACT_EXPAND, 20, 20, 40, 5, 7, 0));  // not adjacent
      send_item(make_item(2'd3, 5, 5, 5, 5, 1, 1));           // unused action
   endtask

   // obstacles and goals
   task automatic test_goals_and_obstacles;
      send_item(make_item(ACT_LOAD, 31, 30, 0, 0, 0, 1));
      send_item(make_item(ACT_LOAD, 30, 29, 0, 0, 0, 1));
      send_item(make_item(ACT_EXPAND, 30, 30, 30, 30, 5, 0));
      send_item(make_item(ACT_LOAD, 31, 30, 0, 0, 0, 0));
      send_item(make_item(ACT_GOAL, 0, 0, 0, 0, 0, 0));
      send_item(make_item(ACT_EXPAND, 30, 30, 30, 30, 5, 0));
      send_item(make_item(ACT_GOAL, 63, 63, 63, 63, 65535, 1));
      send_item(make_item(ACT_EXPAND, 62, 62, 62, 62, 9, 0));
      send_item(make_item(ACT_EXPAND, 1, 1, 1, 1, 9, 0));
   endtask

   // random items, half of them expansions from real neighbors
   task automatic test_random(int n);
      req_type it;
      int sel, c, r;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 19);
         c = $urandom_range(0, 63);
         r = $urandom_range(0, 63);
         if (sel < 3) begin
            it = make_item(ACT_LOAD, c, r, 0, 0, 0, $urandom_range(0, 3) == 0);
         end else if (sel < 4) begin
            it = make_item(ACT_GOAL, c, r, 0, 0, 0, 0);
         end else if (sel < 8) begin
            it = make_item(ACT_EXPAND, c, r, c, r, $urandom_range(0, 65535), 0);
         end else if (sel < 18) begin
            it = expand_from(c, r, $urandom_range(0, 5), $urandom_range(0, 65535));
         end else begin
            it = $bits(req_type)'({$urandom, $urandom});
            it.action = 2'($urandom_range(0, 3));
            if (it.action == ACT_GOAL) it.action = ACT_EXPAND;
         end
         it.blocked = (it.action == ACT_LOAD) ? it.blocked : 1'($urandom_range(0, 1));
         send_item(it);
      end
   endtask

   // receiver holds off long while items keep coming
   task automatic test_backpressure;
      hold_cycles = 600;
      for (int k = 0; k < 6; k++) send_item(expand_from(33, 33, k, 1000 + k));
      drain();
      send_item(make_item(ACT_EXPAND, 33, 34, 33, 34, 12, 0));
   endtask

   task automatic test_bounds;
      write_reg(REG_COL_MIN, 6'd10);
      write_reg(REG_COL_MAX, 6'd20);
      write_reg(REG_ROW_MIN, 6'd10);
      write_reg(REG_ROW_MAX, 6'd20);
      send_item(make_item(ACT_EXPAND, 10, 10, 10, 10, 3, 0));
      send_item(make_item(ACT_EXPAND, 20, 21, 20, 21, 3, 0));
      test_random(30);
      drain();
      write_reg(REG_COL_MIN, 6'd63);
      write_reg(REG_COL_MAX, 6'd0);
      send_item(make_item(ACT_EXPAND, 30, 30, 30, 30, 3, 0));
      drain();
      write_reg(REG_COL_MIN, 6'd0);
      write_reg(REG_COL_MAX, 6'd63);
      write_reg(REG_ROW_MIN, 6'd0);
      write_reg(REG_ROW_MAX, 6'd63);
   endtask

   initial begin
      n_errs = 0;
      n_goals = 0;
      lim_cmin = 0; lim_cmax = 63; lim_rmin = 0; lim_rmax = 63;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_no_goals();
      test_goals_and_obstacles();
      test_random(20);
      drain();
      test_bounds();
      test_backpressure();
      test_random(20);
      // final stretch runs without idling
      src_idle_on = 1'b0;
      sink_idle_on = 1'b0;
      test_random(20);
      drain();
      if (n_errs == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end
endmodule

@@ sim.f @@
src/hgse_pkg.sv
src/hgse_ram.sv
src/hgse_isqrt.sv
src/hex_grid_successor_expander.sv
src/hgse_checker.sv
tb/tb_top.sv
